@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every edge once reset is released
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");
// cond must never be seen at an edge once reset is released
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/core/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_W    = 64;
    localparam int MAG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int STORE_DEPTH = 16;
    localparam int IDX_W      = 4;
    localparam int CONV_CNT_W = 5;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 31;
    localparam int OUT_DATA_W = 40;
    localparam int OP_W       = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;

    typedef enum logic [OP_W-1:0] {
        OP_SDEC   = 2'd0,
        OP_UDEC   = 2'd1,
        OP_HEX_LO = 2'd2,
        OP_HEX_UP = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_MOVE,
        S_STORE,
        S_SIGN,
        S_EMIT
    } t_state;

    // one character handed to the output stage
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_push;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input t_opcode op);
        logic [CHAR_W-1:0] base;
        if (d < 4'd10) begin
            base = CHAR_ZERO;
        end else if (op == OP_HEX_UP) begin
            base = CHAR_A_UP - 8'd10;
        end else begin
            base = CHAR_A_LO - 8'd10;
        end
        return base + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    endfunction

endpackage

@@ rtl/core/itoa_bcd.sv @@
// ----------------------------------------------------------------------------
// itoa_bcd
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle while i_step is high.
// ----------------------------------------------------------------------------
module itoa_bcd (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_step,
    input  logic [itoa_pkg::MAG_W-1:0]  i_bin,
    output logic [itoa_pkg::BCD_W-1:0]  o_bcd
);
    import itoa_pkg::*;

    logic [MAG_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] adj;

    // each decimal cell corrects itself before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (i_step) begin
            r_bcd <= {adj[BCD_W-2:0], r_bin[MAG_W-1]};
            r_bin <= {r_bin[MAG_W-2:0], 1'b0};
        end
    end

    assign o_bcd = r_bcd;

endmodule

@@ rtl/core/itoa_out.sv @@
// ----------------------------------------------------------------------------
// itoa_out
// Output register for characters with the saturating character counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itoa_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  itoa_pkg::t_push                  i_push,
    output logic                             o_can_push,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    // tdata: [7:0] character, [38:8] char_count, [39] zero
    output logic [itoa_pkg::OUT_DATA_W-1:0]  o_tdata,
    output logic                             o_tlast
);
    import itoa_pkg::*;

    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [COUNT_W-1:0] r_count;

    assign o_can_push = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
            if (r_count != COUNT_MAX) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_char <= i_push.ch;
            r_last <= i_push.last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {1'b0, r_count, r_char};
    assign o_tlast  = r_last;

    `ASSERT_NEVER(a_no_overrun, i_clk, i_rst_n, i_push.valid && r_valid && !i_tready)
    `ASSERT_PROP(a_count_step, i_clk, i_rst_n, (i_push.valid && r_count != COUNT_MAX) |=> (r_count == $past(r_count) + COUNT_W'(1)))
    `ASSERT_PROP(a_count_live, i_clk, i_rst_n, r_valid |-> (r_count != '0))

endmodule

@@ rtl/core/integer_to_ascii_formatter_unit.sv @@
// Hex items go from acceptance straight to the nibble store; decimal items pass the BCD converter first.
// Throughput: one character per cycle while the output register can take it; the next item is taken the cycle
//   after the last character enters the output register.
// Rate is set by the 32-step bit-serial BCD converter (decimal only) and the nibble store pass.
// Reset (i_rst_n low, synchronous) clears control state and the character count.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats an integer as decimal or hex ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_ascii_formatter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tvalid,
    output logic                             o_tready,
    // tdata: [63:0] value
    input  logic [itoa_pkg::VALUE_W-1:0]     i_tdata,
    // tuser: [1:0] opcode
    input  logic [itoa_pkg::OP_W-1:0]        i_tuser,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    // tdata: [7:0] character, [38:8] char_count, [39] zero
    output logic [itoa_pkg::OUT_DATA_W-1:0]  o_tdata,
    output logic                             o_tlast
);
    import itoa_pkg::*;

    t_state                 r_state, n_state;
    t_opcode                r_op;
    logic                   r_neg;
    logic [VALUE_W-1:0]     r_work;
    logic [CONV_CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]       r_top;
    logic [DIGIT_W-1:0]     r_digits [STORE_DEPTH];

    logic                   accept;
    t_opcode                in_op;
    logic [MAG_W-1:0]       in_lo;
    logic                   in_neg;
    logic [MAG_W-1:0]       in_mag;
    logic [BCD_W-1:0]       bcd;
    logic                   bcd_load;
    logic                   bcd_step;
    logic                   can_push;
    t_push                  push;
    logic [DIGIT_W-1:0]     nib;
    logic                   store_last;
    logic [IDX_W-1:0]       n_top_store;

    assign o_tready = (r_state == S_IDLE);
    assign accept   = i_tvalid && o_tready;
    assign in_op    = t_opcode'(i_tuser);
    assign in_lo    = i_tdata[MAG_W-1:0];
    assign in_neg   = (in_op == OP_SDEC) && in_lo[MAG_W-1];
    assign in_mag   = in_neg ? (~in_lo + MAG_W'(1)) : in_lo;

    assign nib         = r_work[DIGIT_W-1:0];
    assign store_last  = (r_cnt[IDX_W-1:0] == IDX_W'(STORE_DEPTH - 1));
    assign n_top_store = (nib != '0) ? r_cnt[IDX_W-1:0] : r_top;

    itoa_bcd u_bcd (
        .i_clk  (i_clk),
        .i_load (bcd_load),
        .i_step (bcd_step),
        .i_bin  (in_mag),
        .o_bcd  (bcd)
    );

    itoa_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_can_push (can_push),
        .o_tvalid   (o_tvalid),
        .i_tready   (i_tready),
        .o_tdata    (o_tdata),
        .o_tlast    (o_tlast)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = in_op[1] ? S_STORE : S_CONV;
                end
            end
            S_CONV: begin
                if (r_cnt == CONV_CNT_W'(MAG_W - 1)) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                if (store_last) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (can_push) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_push && r_top == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        bcd_load   = accept && !in_op[1];
        bcd_step   = (r_state == S_CONV);
        push.valid = ((r_state == S_SIGN) || (r_state == S_EMIT)) && can_push;
        push.ch    = (r_state == S_SIGN) ? CHAR_MINUS : digit_char(r_digits[r_top], r_op);
        push.last  = (r_state == S_EMIT) && (r_top == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_SDEC;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op  <= in_op;
                        r_neg <= in_neg;
                        r_cnt <= '0;
                        r_top <= '0;
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt + CONV_CNT_W'(1);
                end
                S_MOVE: begin
                    r_cnt <= '0;
                end
                S_STORE: begin
                    r_top <= n_top_store;
                    r_cnt <= r_cnt + CONV_CNT_W'(1);
                end
                S_EMIT: begin
                    if (can_push && r_top != '0) begin
                        r_top <= r_top - IDX_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // nibble shift register feeding the digit store
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= i_tdata;
        end else if (r_state == S_MOVE) begin
            r_work <= {{(VALUE_W-BCD_W){1'b0}}, bcd};
        end else if (r_state == S_STORE) begin
            r_work <= {{DIGIT_W{1'b0}}, r_work[VALUE_W-1:DIGIT_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE) begin
            r_digits[r_cnt[IDX_W-1:0]] <= nib;
        end
    end

    `ASSERT_PROP(a_conv_decimal, i_clk, i_rst_n, (r_state == S_CONV) |-> (r_op == OP_SDEC || r_op == OP_UDEC))
    `ASSERT_PROP(a_neg_signed, i_clk, i_rst_n, r_neg |-> (r_op == OP_SDEC))
    `ASSERT_PROP(a_last_ends, i_clk, i_rst_n, (push.valid && push.last) |=> (r_state == S_IDLE))

endmodule

@@ verif/tb_integer_to_ascii_formatter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_unit
// Sends numbers in all four formats and checks every character, its last flag
// and the running character count against an in-bench model of the formatter.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_unit;

    import itoa_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int TAIL_WAIT  = 80;

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } t_char_exp;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_tvalid;
    logic                   o_tready;
    logic [VALUE_W-1:0]     i_tdata;
    logic [OP_W-1:0]        i_tuser;
    logic                   o_tvalid;
    logic                   i_tready;
    logic [OUT_DATA_W-1:0]  o_tdata;
    logic                   o_tlast;

    t_char_exp          expected_chars[$];
    logic [COUNT_W-1:0] chars_sent_total;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 error_count;

    integer_to_ascii_formatter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .o_tready (o_tready),
        .i_tdata  (i_tdata),
        .i_tuser  (i_tuser),
        .o_tvalid (o_tvalid),
        .i_tready (i_tready),
        .o_tdata  (o_tdata),
        .o_tlast  (o_tlast)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // queue one expected character, count saturates at all ones
    function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic last);
        t_char_exp e;
        if (chars_sent_total != COUNT_MAX) begin
            chars_sent_total = chars_sent_total + 1'b1;
        end
        e.ch    = ch;
        e.last  = last;
        e.count = chars_sent_total;
        expected_chars.push_back(e);
    endfunction

    function automatic void predict_text(input logic [VALUE_W-1:0] value, input t_opcode op);
        logic [3:0]  digs [16];
        logic [31:0] mag;
        logic [63:0] hexv;
        logic        neg;
        int          n;
        logic [CHAR_W-1:0] ch;
        n   = 0;
        neg = 1'b0;
        if (op == OP_SDEC || op == OP_UDEC) begin
            mag = value[31:0];
            if (op == OP_SDEC && mag[31]) begin
                neg = 1'b1;
                mag = ~mag + 32'd1;   // most negative stays 0x80000000 = 2147483648
            end
            do begin
                digs[n] = 4'(mag % 32'd10);
                n++;
                mag = mag / 32'd10;
            end while (mag != 0 && n < 16);
        end else begin
            hexv = value;
            do begin
                digs[n] = hexv[3:0];
                n++;
                hexv = hexv >> 4;
            end while (hexv != 0 && n < 16);
        end
        if (neg) begin
            push_char("-", 1'b0);
        end
        while (n > 0) begin
            n--;
            if (digs[n] < 4'd10) begin
                ch = 8'h30 + 8'(digs[n]);
            end else if (op == OP_HEX_UP) begin
                ch = "A" + 8'(digs[n] - 4'd10);
            end else begin
                ch = "a" + 8'(digs[n] - 4'd10);
            end
            push_char(ch, n == 0);
        end
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic send_number(input logic [VALUE_W-1:0] value, input t_opcode op);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_tvalid <= 1'b1;
        i_tdata  <= value;
        i_tuser  <= op;
        do @(posedge i_clk); while (!o_tready);
        predict_text(value, op);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: v = v >> $urandom_range(0, 63);
            1: v = 64'($urandom_range(0, 20));
            2: v = {v[63:32], 32'd0 - 32'($urandom_range(1, 1000))};
            3: v = {v[63:32], 32'(v[31:0] >> $urandom_range(0, 31))};
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_format_edges();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_number(64'd0, OP_SDEC);
        send_number(64'd0, OP_UDEC);
        send_number(64'd0, OP_HEX_LO);
        send_number(64'd0, OP_HEX_UP);
        send_number(64'h0000_0000_8000_0000, OP_SDEC);   // most negative
        send_number(64'h0000_0000_7FFF_FFFF, OP_SDEC);
        send_number(64'h0000_0000_FFFF_FFFF, OP_SDEC);
        send_number(64'h0000_0000_FFFF_FFFF, OP_UDEC);
        send_number(64'hDEAD_BEEF_0000_007B, OP_UDEC);   // upper bits ignored
        send_number(64'hFFFF_FFFF_8000_0000, OP_SDEC);
        send_number(64'hFFFF_FFFF_0000_0009, OP_SDEC);
        send_number(64'd10, OP_UDEC);
        send_number(64'd1000000000, OP_UDEC);
        send_number(64'h0000_0000_8000_0000, OP_UDEC);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_HEX_LO);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_HEX_UP);
        send_number(64'h8000_0000_0000_0000, OP_HEX_LO);
        send_number(64'h0123_4567_89AB_CDEF, OP_HEX_LO);
        send_number(64'h0123_4567_89AB_CDEF, OP_HEX_UP);
        send_number(64'h0000_0000_0000_000A, OP_HEX_UP);
        send_number(64'h0000_0000_0000_000F, OP_HEX_LO);
        wait_drained();
    endtask

    task automatic test_random_numbers(input int src_pct, input int sink_pct,
                                       input int n_items);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < n_items; i++) begin
            send_number(random_value(), t_opcode'($urandom_range(0, 3)));
        end
    endtask

    // sender holds off until the block has emitted everything owed
    task automatic test_pause_until_drained();
        src_idle_pct  = 0;
        sink_idle_pct = 30;
        for (int i = 0; i < 4; i++) begin
            send_number(random_value(), t_opcode'($urandom_range(0, 3)));
        end
        wait_drained();
        send_number(random_value(), OP_SDEC);
    endtask

    // receiver ready with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_tready <= 1'b0;
        end else begin
            i_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_char_exp e;
        if (i_rst_n && o_tvalid && i_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character transaction: 0x%0h", o_tdata[7:0]);
                error_count++;
            end else begin
                e = expected_chars.pop_front();
                if (o_tdata[7:0] !== e.ch) begin
                    $error("character: expected 0x%0h, got 0x%0h", e.ch, o_tdata[7:0]);
                    error_count++;
                end
                if (o_tlast !== e.last) begin
                    $error("last_char: expected %0d, got %0d", e.last, o_tlast);
                    error_count++;
                end
                if (o_tdata[38:8] !== e.count) begin
                    $error("char_count: expected %0d, got %0d", e.count, o_tdata[38:8]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_integer_to_ascii_formatter_unit: FAIL");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_tvalid         = 1'b0;
        i_tdata          = '0;
        i_tuser          = OP_SDEC;
        i_tready         = 1'b0;
        chars_sent_total = '0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        error_count      = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_format_edges();
        test_random_numbers(23, 56, 100);
        test_pause_until_drained();
        test_random_numbers(56, 23, 100);
        test_random_numbers(0, 0, 100);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_integer_to_ascii_formatter_unit: PASS");
        end else begin
            $display("tb_integer_to_ascii_formatter_unit: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/itoa_pkg.sv
rtl/core/itoa_bcd.sv
rtl/core/itoa_out.sv
rtl/core/integer_to_ascii_formatter_unit.sv
verif/tb_integer_to_ascii_formatter_unit.sv
